FILE: sv/tatp_pkg.sv
// Shared types, constants and width helpers for the two-axis trapezoid planner.
// Used by the register file, controller, datapath and top level.
// No dependencies.
package tatp_pkg;

  localparam int DATA_W      = 32;
  localparam int PERIOD_W    = 10;
  localparam int IDX_W       = 3;
  localparam int FRAC_BITS   = 16;
  localparam int DV_W        = DATA_W + PERIOD_W;   // acc * period
  localparam int NUM_W       = DV_W + PERIOD_W;     // dv * period
  localparam int ENC_SCALE   = 10000;
  localparam int ENC_SCALE_W = 14;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(10);
  localparam logic [DATA_W-1:0]   LIMIT_RST  = DATA_W'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_PERIOD     = 3'd0,
    REG_AZ_MAX_VEL = 3'd1,
    REG_AZ_MAX_ACC = 3'd2,
    REG_EL_MAX_VEL = 3'd3,
    REG_EL_MAX_ACC = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [DATA_W-1:0]   az_max_vel;
    logic [DATA_W-1:0]   az_max_acc;
    logic [DATA_W-1:0]   el_max_vel;
    logic [DATA_W-1:0]   el_max_acc;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_DV, OP_NUM, OP_CMP, OP_MULA, OP_MULB_LD, OP_MULB,
    OP_SQ_LD, OP_SQRT, OP_VEL, OP_DELTA, OP_POS, OP_ENC_MUL, OP_ENC, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic seq_ok;
    logic run;
    logic out_busy;
  } stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DV, ST_NUM, ST_CMP, ST_MULA, ST_MULB_LD, ST_MULB, ST_SQ_LD,
    ST_SQRT, ST_VEL, ST_DELTA, ST_POS, ST_ENC_MUL, ST_ENC, ST_FINISH
  } state_t;

  // Error magnitude width for a given position width.
  function automatic int mag_w(input int sw);
    return sw + 1;
  endfunction

  // Width of 2*acc*mag + dv*dv, rounded up to an even number.
  function automatic int arg_w(input int sw);
    int a;
    int b;
    int m;
    a = DATA_W + 1 + mag_w(sw);
    b = 2 * DV_W;
    m = ((a > b) ? a : b) + 1;
    return m + (m % 2);
  endfunction

  function automatic int root_w(input int sw);
    return arg_w(sw) / 2;
  endfunction

endpackage

FILE: sv/two_axis_trapezoid_planner_top.sv
// Channel  | handshake             | payload
// -------- | --------------------- | -------------------------------------------------
// in       | in_valid / in_ready   | packet_id, az_on, el_on, az_target, el_target
// out      | out_valid / out_ready | reply_id, az_encoder, el_encoder, az_active, el_active
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request in sequence takes each axis through its fixed steps and, when the axis moves,
// also through the bit-serial multiplier (two passes, with a load before the second)
// and the square root with its load.
// A request out of sequence is accepted but gives no result.
// Reset is synchronous; the output register lets the next request in while a result waits,
// and the sequencer holds in its last step only if that result is still not taken.
// Depends on tatp_pkg, tatp_regs, tatp_ctrl and tatp_dp.
module two_axis_trapezoid_planner_top #(
  parameter int STATE_WIDTH = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tatp_pkg::DATA_W-1:0]        packet_id,
  input  logic                               az_on,
  input  logic                               el_on,
  input  logic signed [tatp_pkg::DATA_W-1:0] az_target,
  input  logic signed [tatp_pkg::DATA_W-1:0] el_target,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tatp_pkg::DATA_W-1:0]        reply_id,
  output logic signed [tatp_pkg::DATA_W-1:0] az_encoder,
  output logic signed [tatp_pkg::DATA_W-1:0] el_encoder,
  output logic                               az_active,
  output logic                               el_active,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tatp_pkg::IDX_W-1:0]         cfg_index,
  input  logic [tatp_pkg::DATA_W-1:0]        cfg_data
);

  tatp_pkg::cfg_t  cfg;
  tatp_pkg::cmd_t  cmd;
  tatp_pkg::stat_t stat;

  tatp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tatp_ctrl #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tatp_dp #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .packet_id  (packet_id),
    .az_on      (az_on),
    .el_on      (el_on),
    .az_target  (az_target),
    .el_target  (el_target),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_id   (reply_id),
    .az_encoder (az_encoder),
    .el_encoder (el_encoder),
    .az_active  (az_active),
    .el_active  (el_active)
  );

endmodule

FILE: sv/tatp_regs.sv
// Configuration register file of the trapezoid planner.
// Depends on tatp_pkg.
module tatp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tatp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tatp_pkg::DATA_W-1:0]   cfg_data,
  output tatp_pkg::cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period     <= tatp_pkg::PERIOD_RST;
      cfg.az_max_vel <= tatp_pkg::LIMIT_RST;
      cfg.az_max_acc <= tatp_pkg::LIMIT_RST;
      cfg.el_max_vel <= tatp_pkg::LIMIT_RST;
      cfg.el_max_acc <= tatp_pkg::LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tatp_pkg::REG_PERIOD:     cfg.period     <= cfg_data[tatp_pkg::PERIOD_W-1:0];
        tatp_pkg::REG_AZ_MAX_VEL: cfg.az_max_vel <= cfg_data;
        tatp_pkg::REG_AZ_MAX_ACC: cfg.az_max_acc <= cfg_data;
        tatp_pkg::REG_EL_MAX_VEL: cfg.el_max_vel <= cfg_data;
        tatp_pkg::REG_EL_MAX_ACC: cfg.el_max_acc <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/tatp_ctrl.sv
// Sequencer of the trapezoid planner: walks each axis through the step.
// Depends on tatp_pkg; drives tatp_dp through cmd_t and reads stat_t.
module tatp_ctrl #(
  parameter int STATE_WIDTH = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tatp_pkg::stat_t stat,
  output tatp_pkg::cmd_t  cmd
);

  localparam int MAG_W  = tatp_pkg::mag_w(STATE_WIDTH);
  localparam int ROOT_W = tatp_pkg::root_w(STATE_WIDTH);
  localparam int MAX_A  = (MAG_W > tatp_pkg::DV_W) ? MAG_W : tatp_pkg::DV_W;
  localparam int MAX_L  = (MAX_A > ROOT_W) ? MAX_A : ROOT_W;
  localparam int CNT_W  = $clog2(MAX_L);

  tatp_pkg::state_t state, state_next;
  logic             axis, axis_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tatp_pkg::ST_IDLE;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd.op     = tatp_pkg::OP_IDLE;
    cmd.axis   = axis;
    unique case (state)
      tatp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = tatp_pkg::OP_ACCEPT;
          if (stat.seq_ok) begin
            state_next = tatp_pkg::ST_DV;
            axis_next  = 1'b0;
          end
        end
      end
      tatp_pkg::ST_DV: begin
        cmd.op     = tatp_pkg::OP_DV;
        state_next = tatp_pkg::ST_NUM;
      end
      tatp_pkg::ST_NUM: begin
        cmd.op     = tatp_pkg::OP_NUM;
        state_next = tatp_pkg::ST_CMP;
      end
      tatp_pkg::ST_CMP: begin
        cmd.op = tatp_pkg::OP_CMP;
        // An axis inside its deadband, or disabled, skips the square root.
        if (stat.run) begin
          cnt_next   = CNT_W'(MAG_W - 1);
          state_next = tatp_pkg::ST_MULA;
        end else begin
          state_next = tatp_pkg::ST_VEL;
        end
      end
      tatp_pkg::ST_MULA: begin
        cmd.op   = tatp_pkg::OP_MULA;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = tatp_pkg::ST_MULB_LD;
        end
      end
      tatp_pkg::ST_MULB_LD: begin
        cmd.op     = tatp_pkg::OP_MULB_LD;
        cnt_next   = CNT_W'(tatp_pkg::DV_W - 1);
        state_next = tatp_pkg::ST_MULB;
      end
      tatp_pkg::ST_MULB: begin
        cmd.op   = tatp_pkg::OP_MULB;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = tatp_pkg::ST_SQ_LD;
        end
      end
      tatp_pkg::ST_SQ_LD: begin
        cmd.op     = tatp_pkg::OP_SQ_LD;
        cnt_next   = CNT_W'(ROOT_W - 1);
        state_next = tatp_pkg::ST_SQRT;
      end
      tatp_pkg::ST_SQRT: begin
        cmd.op   = tatp_pkg::OP_SQRT;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = tatp_pkg::ST_VEL;
        end
      end
      tatp_pkg::ST_VEL: begin
        cmd.op     = tatp_pkg::OP_VEL;
        state_next = tatp_pkg::ST_DELTA;
      end
      tatp_pkg::ST_DELTA: begin
        cmd.op     = tatp_pkg::OP_DELTA;
        state_next = tatp_pkg::ST_POS;
      end
      tatp_pkg::ST_POS: begin
        cmd.op     = tatp_pkg::OP_POS;
        state_next = tatp_pkg::ST_ENC_MUL;
      end
      tatp_pkg::ST_ENC_MUL: begin
        cmd.op     = tatp_pkg::OP_ENC_MUL;
        state_next = tatp_pkg::ST_ENC;
      end
      tatp_pkg::ST_ENC: begin
        cmd.op = tatp_pkg::OP_ENC;
        if (axis) begin
          state_next = tatp_pkg::ST_FINISH;
        end else begin
          axis_next  = 1'b1;
          state_next = tatp_pkg::ST_DV;
        end
      end
      tatp_pkg::ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.op     = tatp_pkg::OP_FINISH;
          state_next = tatp_pkg::ST_IDLE;
        end
      end
      default: state_next = tatp_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: sv/tatp_dp.sv
// Datapath of the trapezoid planner: axis state, deadband compare, shift-add
// multiplier, digit-by-digit square root and the output register.
// Depends on tatp_pkg; commanded by tatp_ctrl.
module tatp_dp #(
  parameter int STATE_WIDTH = 48
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tatp_pkg::cfg_t                     cfg,
  input  tatp_pkg::cmd_t                     cmd,
  output tatp_pkg::stat_t                    stat,
  input  logic [tatp_pkg::DATA_W-1:0]        packet_id,
  input  logic                               az_on,
  input  logic                               el_on,
  input  logic signed [tatp_pkg::DATA_W-1:0] az_target,
  input  logic signed [tatp_pkg::DATA_W-1:0] el_target,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tatp_pkg::DATA_W-1:0]        reply_id,
  output logic signed [tatp_pkg::DATA_W-1:0] az_encoder,
  output logic signed [tatp_pkg::DATA_W-1:0] el_encoder,
  output logic                               az_active,
  output logic                               el_active
);

  localparam int SW     = STATE_WIDTH;
  localparam int DW     = tatp_pkg::DATA_W;
  localparam int DV_W   = tatp_pkg::DV_W;
  localparam int NUM_W  = tatp_pkg::NUM_W;
  localparam int MAG_W  = tatp_pkg::mag_w(SW);
  localparam int MK_W   = MAG_W + 10;
  localparam int ARG_W  = tatp_pkg::arg_w(SW);
  localparam int ROOT_W = tatp_pkg::root_w(SW);
  localparam int SR_W   = ROOT_W + 3;
  localparam int MB_W   = (MAG_W > DV_W) ? MAG_W : DV_W;
  localparam int DF_W   = SW + 2;
  localparam int CMP_W  = (MK_W > NUM_W) ? MK_W : NUM_W;
  localparam int VW     = DW + 2;
  localparam int SL_W   = DV_W + 2;
  localparam int D_W    = VW + tatp_pkg::PERIOD_W + 1;
  localparam int PS_W   = ((SW > D_W) ? SW : D_W) + 1;
  localparam int EP_W   = SW + tatp_pkg::ENC_SCALE_W;
  localparam int EV_W   = EP_W - tatp_pkg::FRAC_BITS;
  localparam int E_W    = (EV_W > DW + 1) ? EV_W : DW + 1;

  // Architectural state
  logic [DW-1:0]        last_id;
  logic signed [SW-1:0] pos [2];
  logic signed [VW-1:0] vel [2];
  logic signed [DW-1:0] goal [2];
  logic                 en [2];

  // Pending packet, committed once both axes have stepped
  logic [DW-1:0]        pkt_id;
  logic                 pkt_on [2];
  logic signed [DW-1:0] pkt_goal [2];

  // Working registers
  logic [DV_W-1:0]        dv;
  logic [NUM_W-1:0]       num;
  logic [MAG_W-1:0]       mag;
  logic [MK_W-1:0]        magk;
  logic                   up;
  logic                   run_r;
  logic [ARG_W-1:0]       ma;
  logic [MB_W-1:0]        mb;
  logic [ARG_W-1:0]       sum;
  logic [ARG_W-1:0]       rad;
  logic [SR_W-1:0]        sqrem;
  logic [ROOT_W-1:0]      root;
  logic signed [D_W-1:0]  delta;
  logic [EP_W-1:0]        enc_prod;
  logic                   enc_neg;
  logic [DW-1:0]          enc [2];
  logic                   act [2];

  // Axis selection
  logic [DW-1:0]        acc_sel;
  logic [DW-1:0]        vmax_sel;
  logic signed [SW-1:0] pos_sel;
  logic signed [VW-1:0] vel_sel;

  assign acc_sel  = cmd.axis ? cfg.el_max_acc : cfg.az_max_acc;
  assign vmax_sel = cmd.axis ? cfg.el_max_vel : cfg.az_max_vel;
  assign pos_sel  = pos[cmd.axis];
  assign vel_sel  = vel[cmd.axis];

  // Error towards the goal
  logic signed [DF_W-1:0] diff;
  assign diff = DF_W'(goal[cmd.axis]) - DF_W'(pos_sel);

  // Square root step: two radicand bits a cycle
  logic [SR_W-1:0] sq_t;
  logic [SR_W-1:0] sq_trial;
  assign sq_t     = {sqrem[SR_W-3:0], rad[ARG_W-1:ARG_W-2]};
  assign sq_trial = SR_W'({root, 2'b01});

  // Velocity request and slew
  logic [ROOT_W-1:0]      spd_full;
  logic [DW-1:0]          spd;
  logic signed [SL_W-1:0] vreq;
  logic signed [SL_W-1:0] sdv;
  logic signed [SL_W-1:0] v_hi;
  logic signed [SL_W-1:0] v_lo;
  logic signed [SL_W-1:0] vnew;

  always_comb begin
    spd_full = root - ROOT_W'(dv);
    spd      = (spd_full > ROOT_W'(vmax_sel)) ? vmax_sel : spd_full[DW-1:0];
    if (!run_r) begin
      vreq = '0;
    end else if (up) begin
      vreq = $signed(SL_W'(spd));
    end else begin
      vreq = -$signed(SL_W'(spd));
    end
    sdv  = $signed(SL_W'(dv));
    v_hi = SL_W'(vel_sel) + sdv;
    v_lo = SL_W'(vel_sel) - sdv;
    if (vreq > v_hi) begin
      vnew = v_hi;
    end else if (vreq < v_lo) begin
      vnew = v_lo;
    end else begin
      vnew = vreq;
    end
  end

  // Position integration with saturation
  logic signed [PS_W-1:0] psum;
  logic signed [PS_W-1:0] p_hi;
  logic signed [PS_W-1:0] p_lo;
  logic signed [SW-1:0]   pnew;

  always_comb begin
    p_hi = $signed({{(PS_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}});
    p_lo = -p_hi - PS_W'(1);
    psum = PS_W'(pos_sel) + PS_W'(delta);
    if (psum > p_hi) begin
      pnew = p_hi[SW-1:0];
    end else if (psum < p_lo) begin
      pnew = p_lo[SW-1:0];
    end else begin
      pnew = psum[SW-1:0];
    end
  end

  // Encoder scaling
  logic [SW-1:0] pmag;
  logic [E_W-1:0] ev;
  logic [E_W-1:0] elim;
  logic [E_W-1:0] evc;
  logic [DW-1:0]  enc_val;

  always_comb begin
    pmag    = pos_sel[SW-1] ? (SW'(0) - SW'(pos_sel)) : SW'(pos_sel);
    ev      = E_W'(enc_prod[EP_W-1:tatp_pkg::FRAC_BITS]);
    elim    = enc_neg ? (E_W'(1) << (DW - 1)) : ((E_W'(1) << (DW - 1)) - E_W'(1));
    evc     = (ev > elim) ? elim : ev;
    enc_val = enc_neg ? (DW'(0) - evc[DW-1:0]) : evc[DW-1:0];
  end

  // The error is outside the deadband floor(num / 1000) exactly when 1000 * mag > num.
  assign stat.seq_ok   = packet_id == (last_id + DW'(1));
  assign stat.run      = en[cmd.axis] && (CMP_W'(magk) > CMP_W'(num));
  assign stat.out_busy = out_valid && !out_ready;

  // State that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      last_id   <= '0;
      pos[0]    <= '0;
      pos[1]    <= '0;
      vel[0]    <= '0;
      vel[1]    <= '0;
      goal[0]   <= '0;
      goal[1]   <= '0;
      en[0]     <= 1'b0;
      en[1]     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (cmd.op != tatp_pkg::OP_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        tatp_pkg::OP_ACCEPT: last_id <= packet_id;
        tatp_pkg::OP_VEL:    vel[cmd.axis] <= vnew[VW-1:0];
        tatp_pkg::OP_POS:    pos[cmd.axis] <= pnew;
        tatp_pkg::OP_FINISH: begin
          goal[0]   <= pkt_goal[0];
          goal[1]   <= pkt_goal[1];
          en[0]     <= pkt_on[0];
          en[1]     <= pkt_on[1];
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tatp_pkg::OP_ACCEPT: begin
        pkt_id      <= packet_id;
        pkt_on[0]   <= az_on;
        pkt_on[1]   <= el_on;
        pkt_goal[0] <= az_target;
        pkt_goal[1] <= el_target;
      end
      tatp_pkg::OP_DV: begin
        dv  <= DV_W'(acc_sel) * DV_W'(cfg.period);
        up  <= diff >= 0;
        mag <= (diff >= 0) ? MAG_W'(diff) : MAG_W'(-diff);
      end
      tatp_pkg::OP_NUM: begin
        num  <= NUM_W'(dv) * NUM_W'(cfg.period);
        // 1000 is 1024 - 16 - 8.
        magk <= (MK_W'(mag) << 10) - (MK_W'(mag) << 4) - (MK_W'(mag) << 3);
      end
      tatp_pkg::OP_CMP: begin
        run_r <= stat.run;
        ma    <= ARG_W'({acc_sel, 1'b0});
        mb    <= MB_W'(mag);
        sum   <= '0;
      end
      tatp_pkg::OP_MULA, tatp_pkg::OP_MULB: begin
        if (mb[0]) begin
          sum <= sum + ma;
        end
        ma <= ma << 1;
        mb <= mb >> 1;
      end
      tatp_pkg::OP_MULB_LD: begin
        ma <= ARG_W'(dv);
        mb <= MB_W'(dv);
      end
      tatp_pkg::OP_SQ_LD: begin
        rad   <= sum;
        sqrem <= '0;
        root  <= '0;
      end
      tatp_pkg::OP_SQRT: begin
        rad <= rad << 2;
        if (sq_t >= sq_trial) begin
          sqrem <= sq_t - sq_trial;
          root  <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          sqrem <= sq_t;
          root  <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      tatp_pkg::OP_VEL: begin
        act[cmd.axis] <= run_r || (vnew != '0);
      end
      tatp_pkg::OP_DELTA: begin
        delta <= D_W'(vel_sel) * $signed(D_W'(cfg.period));
      end
      tatp_pkg::OP_ENC_MUL: begin
        enc_neg  <= pos_sel[SW-1];
        enc_prod <= EP_W'(pmag) * EP_W'(tatp_pkg::ENC_SCALE);
      end
      tatp_pkg::OP_ENC: begin
        enc[cmd.axis] <= enc_val;
      end
      tatp_pkg::OP_FINISH: begin
        reply_id   <= pkt_id;
        az_encoder <= enc[0];
        el_encoder <= enc[1];
        az_active  <= act[0];
        el_active  <= act[1];
      end
      default: ;
    endcase
  end

endmodule
